// ===== rtl/core/vfv_pkg.sv =====
// ----------------------------------------------------------------------------
// vfv_pkg: shared types and constants of the voxel face visibility unit
// Field widths, register indexes, item codes and the sequencer state type.
// ----------------------------------------------------------------------------
package vfv_pkg;

  // Default geometry, handed to the top level parameters
  localparam int unsigned CHUNK_SIZE_DEF = 16;
  localparam int unsigned TYPE_BITS_DEF  = 4;

  // Fixed port widths
  localparam int unsigned COORD_W    = 4;
  localparam int unsigned NTYPE_W    = 4;
  localparam int unsigned OUT_TYPE_W = 4;
  localparam int unsigned WORLD_W    = 16;
  localparam int unsigned NUM_FACES  = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 2'd2;

  // Item codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Read sequence: centre at the first step, then one neighbour per step
  localparam logic [STEP_W-1:0] STEP_FIRST = 3'd1;
  localparam logic [STEP_W-1:0] STEP_NEG_Z = 3'd1;
  localparam logic [STEP_W-1:0] STEP_POS_X = 3'd2;
  localparam logic [STEP_W-1:0] STEP_POS_Z = 3'd3;
  localparam logic [STEP_W-1:0] STEP_NEG_X = 3'd4;
  localparam logic [STEP_W-1:0] STEP_POS_Y = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NEG_Y = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST
  } vfv_state_e;

endpackage

// ===== rtl/core/vfv_cell_ram.sv =====
// ----------------------------------------------------------------------------
// vfv_cell_ram: single-port cell store
// One access per cycle, read-first, registered read data held while idle.
// ----------------------------------------------------------------------------
module vfv_cell_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 4
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/voxel_face_visibility_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_face_visibility_unit: hidden face culling over one voxel chunk
// Stores a cubic chunk of block types and reports visible faces of a cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries write and query items.
//   A write stores one cell; writes outside the chunk are
//   dropped. A query reads the centre cell and its six neighbours through the
//   single port of the cell store, one read per cycle, then folds the last
//   neighbour in at a final state, where its result is registered.
//   The output channel (out_valid_o / out_stall_i) has its own register, so
//   the next item is taken while a result still waits. If a finished query
//   finds the output register full and stalled, it holds until that result
//   transfers.
//   Configuration writes (cfg_we_i) set the chunk origin; apply them only
//   while idle.
//   Reset clears the sequencer, the output valid and the origin registers.
//   The cell store has no reset: write the whole chunk before any query.
// ----------------------------------------------------------------------------
module voxel_face_visibility_unit #(
  parameter int unsigned CHUNK_SIZE = vfv_pkg::CHUNK_SIZE_DEF,
  parameter int unsigned TYPE_BITS  = vfv_pkg::TYPE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   op_i,
  input  logic [vfv_pkg::COORD_W-1:0]            cell_x_i,
  input  logic [vfv_pkg::COORD_W-1:0]            cell_y_i,
  input  logic [vfv_pkg::COORD_W-1:0]            cell_z_i,
  input  logic [vfv_pkg::NTYPE_W-1:0]            new_type_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [vfv_pkg::NUM_FACES-1:0]          face_mask_o,
  output logic [vfv_pkg::OUT_TYPE_W-1:0]         cell_type_o,
  output logic signed [vfv_pkg::WORLD_W-1:0]     world_x_o,
  output logic signed [vfv_pkg::WORLD_W-1:0]     world_y_o,
  output logic signed [vfv_pkg::WORLD_W-1:0]     world_z_o,
  input  logic                                   cfg_we_i,
  input  logic [vfv_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [vfv_pkg::CFG_DATA_W-1:0]         cfg_wdata_i
);

  import vfv_pkg::*;

  localparam int unsigned DEPTH = CHUNK_SIZE * CHUNK_SIZE * CHUNK_SIZE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LAST  = CHUNK_SIZE - 1;
  localparam int unsigned NB_W  = COORD_W + 1;

  function automatic logic [AW-1:0] addr_of(input logic [NB_W-1:0] x,
                                            input logic [NB_W-1:0] y,
                                            input logic [NB_W-1:0] z);
    addr_of = AW'(int'(x) * CHUNK_SIZE * CHUNK_SIZE + int'(y) * CHUNK_SIZE + int'(z));
  endfunction

  // Configuration
  logic [WORLD_W-1:0] origin_x_q, origin_y_q, origin_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_wdata_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_wdata_i;
        CFG_ORIGIN_Z: origin_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer state
  vfv_state_e              state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [COORD_W-1:0]      x_q, y_q, z_q;
  logic                    inside_q;
  logic [NUM_FACES-1:0]    edge_q, edge_d;
  logic [NUM_FACES-1:0]    mask_q, mask_d;
  logic [TYPE_BITS-1:0]    type_q, type_d;

  logic                    in_xfer, out_xfer, out_free, out_load;
  logic                    in_inside;
  logic [NUM_FACES-1:0]    in_edge;
  logic                    face_open;
  logic [NUM_FACES-1:0]    final_mask;

  logic                    ram_en, ram_we;
  logic [AW-1:0]           ram_addr;
  logic [TYPE_BITS-1:0]    ram_rdata;
  logic [NB_W-1:0]         nx, ny, nz;

  logic                    out_valid_q;
  logic [NUM_FACES-1:0]    out_mask_q;
  logic [OUT_TYPE_W-1:0]   out_type_q;
  logic [WORLD_W-1:0]      out_wx_q, out_wy_q, out_wz_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_inside = (32'(cell_x_i) <= LAST) && (32'(cell_y_i) <= LAST) &&
                     (32'(cell_z_i) <= LAST);
  // Faces in read order: -z, +x, +z, -x, +y, -y
  assign in_edge = {(cell_y_i == '0), (32'(cell_y_i) == LAST), (cell_x_i == '0),
                    (32'(cell_z_i) == LAST), (32'(cell_x_i) == LAST), (cell_z_i == '0)};

  // Shared compare: open when on the boundary or the neighbour is air
  assign face_open  = edge_q[0] || (ram_rdata == '0);
  assign final_mask = {face_open, mask_q[NUM_FACES-1:1]};

  // Neighbour coordinate for the current step
  always_comb begin
    nx = {1'b0, x_q};
    ny = {1'b0, y_q};
    nz = {1'b0, z_q};
    unique case (step_q)
      STEP_NEG_Z: nz = nz - 1'b1;
      STEP_POS_X: nx = nx + 1'b1;
      STEP_POS_Z: nz = nz + 1'b1;
      STEP_NEG_X: nx = nx - 1'b1;
      STEP_POS_Y: ny = ny + 1'b1;
      STEP_NEG_Y: ny = ny - 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    edge_d   = edge_q;
    mask_d   = mask_q;
    type_d   = type_q;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = addr_of(nx, ny, nz);
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        ram_addr = addr_of({1'b0, cell_x_i}, {1'b0, cell_y_i}, {1'b0, cell_z_i});
        if (in_xfer) begin
          if (op_i == OP_WRITE) begin
            ram_en = in_inside;
            ram_we = in_inside;
          end else begin
            // Read the centre now, neighbours follow
            ram_en  = 1'b1;
            edge_d  = in_edge;
            step_d  = STEP_FIRST;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_en = 1'b1;
        if (step_q == STEP_FIRST) begin
          type_d = ram_rdata;
        end else begin
          mask_d = final_mask;
          edge_d = edge_q >> 1;
        end
        if (step_q == STEP_NEG_Y) begin
          state_d = ST_LAST;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_LAST: begin
        // Read data holds while waiting for the output register
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_FIRST;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q <= edge_d;
    mask_q <= mask_d;
    type_q <= type_d;
    if (in_xfer) begin
      x_q      <= cell_x_i;
      y_q      <= cell_y_i;
      z_q      <= cell_z_i;
      inside_q <= in_inside;
    end
  end

  vfv_cell_ram #(
    .DEPTH(DEPTH),
    .AW   (AW),
    .DW   (TYPE_BITS)
  ) u_cell_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(TYPE_BITS'(new_type_i)),
    .rdata_o(ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mask_q <= (inside_q && (type_q != '0)) ? final_mask : '0;
      out_type_q <= inside_q ? OUT_TYPE_W'(type_q) : '0;
      out_wx_q   <= origin_x_q + WORLD_W'(x_q);
      out_wy_q   <= origin_y_q + WORLD_W'(y_q);
      out_wz_q   <= origin_z_q + WORLD_W'(z_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign face_mask_o = out_mask_q;
  assign cell_type_o = out_type_q;
  assign world_x_o   = out_wx_q;
  assign world_y_o   = out_wy_q;
  assign world_z_o   = out_wz_q;

  // Checks
  a_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (op_i == OP_WRITE) |=> !in_stall_o)
    else $error("write item kept the block busy");

  a_query_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (op_i == OP_QUERY) |=> (state_q == ST_READ) && (step_q == STEP_FIRST))
    else $error("query did not start its read sequence");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (step_q >= STEP_FIRST) && (step_q <= STEP_NEG_Y))
    else $error("read step out of range");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_LAST))
    else $error("result appeared outside the final step");

endmodule

// ===== bench/voxel_face_visibility_unit_test.sv =====
// ----------------------------------------------------------------------------
// voxel_face_visibility_unit_test: self-checking bench for face culling
// Fills the whole chunk, then runs directed and random write/query traffic
// under several chunk origins. A local predictor tracks the cell store and
// the origin, and every query result is checked field by field in order.
// ----------------------------------------------------------------------------
module voxel_face_visibility_unit_test;
  import vfv_pkg::*;

  localparam int unsigned CLK_HALF     = 6;
  localparam int unsigned CLK_PERIOD   = 2 * CLK_HALF;
  localparam int unsigned STORE_DEPTH  = CHUNK_SIZE_DEF * CHUNK_SIZE_DEF * CHUNK_SIZE_DEF;
  localparam int unsigned PHASE_ITEMS  = 210;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RUN_LIMIT    = 2000000;
  localparam logic [COORD_W-1:0]   LAST_CELL  = COORD_W'(CHUNK_SIZE_DEF - 1);
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [NTYPE_W-1:0] ntype;
  } voxel_item_t;

  typedef struct packed {
    logic [NUM_FACES-1:0]      mask;
    logic [OUT_TYPE_W-1:0]     ctype;
    logic signed [WORLD_W-1:0] wx;
    logic signed [WORLD_W-1:0] wy;
    logic signed [WORLD_W-1:0] wz;
  } face_result_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_stall_o;
  logic                      op_i        = OP_WRITE;
  logic [COORD_W-1:0]        cell_x_i    = '0;
  logic [COORD_W-1:0]        cell_y_i    = '0;
  logic [COORD_W-1:0]        cell_z_i    = '0;
  logic [NTYPE_W-1:0]        new_type_i  = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [NUM_FACES-1:0]      face_mask_o;
  logic [OUT_TYPE_W-1:0]     cell_type_o;
  logic signed [WORLD_W-1:0] world_x_o;
  logic signed [WORLD_W-1:0] world_y_o;
  logic signed [WORLD_W-1:0] world_z_o;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0]     cfg_wdata_i = '0;

  voxel_face_visibility_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_z_i    (cell_z_i),
    .new_type_i  (new_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .face_mask_o (face_mask_o),
    .cell_type_o (cell_type_o),
    .world_x_o   (world_x_o),
    .world_y_o   (world_y_o),
    .world_z_o   (world_z_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Predictor state: mirror of the cell store and the chunk origin
  logic [OUT_TYPE_W-1:0]     cells [STORE_DEPTH];
  logic signed [WORLD_W-1:0] org_x = '0;
  logic signed [WORLD_W-1:0] org_y = '0;
  logic signed [WORLD_W-1:0] org_z = '0;

  voxel_item_t  stim_items [$];
  face_result_t faces_due [$];

  int unsigned fail_count    = 0;
  int unsigned cell_writes   = 0;
  int unsigned cell_queries  = 0;
  int unsigned faces_checked = 0;
  int unsigned origin_sets   = 0;

  bit          in_taken     = 1'b0;
  bit          tx_gaps      = 1'b0;
  bit          rx_stalls    = 1'b0;
  int unsigned tx_gap_left  = 0;
  int unsigned rx_left      = 0;
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_seen = 0;

  function automatic face_result_t cull_faces(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y,
                                              input logic [COORD_W-1:0] z);
    face_result_t r;
    r.ctype = cells[{x, y, z}];
    r.mask  = '0;
    // Boundary faces of a solid cell always show
    if (r.ctype != '0) begin
      r.mask[0] = (z == '0)        || (cells[{x, y, z - 4'd1}] == '0);
      r.mask[1] = (x == LAST_CELL) || (cells[{x + 4'd1, y, z}] == '0);
      r.mask[2] = (z == LAST_CELL) || (cells[{x, y, z + 4'd1}] == '0);
      r.mask[3] = (x == '0)        || (cells[{x - 4'd1, y, z}] == '0);
      r.mask[4] = (y == LAST_CELL) || (cells[{x, y + 4'd1, z}] == '0);
      r.mask[5] = (y == '0)        || (cells[{x, y - 4'd1, z}] == '0);
    end
    r.wx = org_x + {{(WORLD_W-COORD_W){1'b0}}, x};
    r.wy = org_y + {{(WORLD_W-COORD_W){1'b0}}, y};
    r.wz = org_z + {{(WORLD_W-COORD_W){1'b0}}, z};
    return r;
  endfunction

  function automatic int unsigned idle_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 8) : $urandom_range(3, 1);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12) return '0;
    if (roll < 24) return LAST_CELL;
    return COORD_W'($urandom_range(LAST_CELL));
  endfunction

  function automatic logic [NTYPE_W-1:0] pick_type();
    logic [NTYPE_W-1:0] t;
    t = NTYPE_W'($urandom_range(15, 1));
    if ($urandom_range(99) < 45) t = '0;
    return t;
  endfunction

  function automatic voxel_item_t random_item();
    voxel_item_t it;
    it.op    = ($urandom_range(99) < 60) ? OP_QUERY : OP_WRITE;
    it.x     = pick_coord();
    it.y     = pick_coord();
    it.z     = pick_coord();
    it.ntype = pick_type();
    return it;
  endfunction

  // Input driver: hold a stalled transfer, otherwise gap or load the next item
  always @(negedge clk_i) begin
    voxel_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      in_valid_i <= 1'b1;
    end else if (tx_gap_left != 0) begin
      tx_gap_left = tx_gap_left - 1;
      in_valid_i <= 1'b0;
    end else if (stim_items.size() != 0) begin
      nxt = stim_items.pop_front();
      in_valid_i <= 1'b1;
      op_i       <= nxt.op;
      cell_x_i   <= nxt.x;
      cell_y_i   <= nxt.y;
      cell_z_i   <= nxt.z;
      new_type_i <= nxt.ntype;
      if (tx_gaps && $urandom_range(99) >= 55) tx_gap_left = idle_len();
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Result receiver: random stalls plus one long hold on request
  always @(negedge clk_i) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen = rx_hold_req;
      rx_left      = LONG_HOLD;
    end
    if (rx_left != 0) begin
      rx_left = rx_left - 1;
      out_stall_i <= 1'b1;
    end else if (rx_stalls && $urandom_range(99) < 20) begin
      rx_left = idle_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check results, then predict from the input transfer of this edge
  always @(posedge clk_i) begin
    face_result_t want;
    if (!rst_ni) begin
      in_taken = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (faces_due.size() == 0) begin
          $error("face result with no query pending: mask %b type %0d",
                 face_mask_o, cell_type_o);
          fail_count++;
        end else begin
          want = faces_due.pop_front();
          faces_checked++;
          if (face_mask_o !== want.mask) begin
            $error("face_mask: expected %b, got %b", want.mask, face_mask_o);
            fail_count++;
          end
          if (cell_type_o !== want.ctype) begin
            $error("cell_type: expected %0d, got %0d", want.ctype, cell_type_o);
            fail_count++;
          end
          if (world_x_o !== want.wx) begin
            $error("world_x: expected %0d, got %0d", want.wx, world_x_o);
            fail_count++;
          end
          if (world_y_o !== want.wy) begin
            $error("world_y: expected %0d, got %0d", want.wy, world_y_o);
            fail_count++;
          end
          if (world_z_o !== want.wz) begin
            $error("world_z: expected %0d, got %0d", want.wz, world_z_o);
            fail_count++;
          end
        end
      end
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        if (op_i == OP_WRITE) begin
          cells[{cell_x_i, cell_y_i, cell_z_i}] = new_type_i[TYPE_BITS_DEF-1:0];
          cell_writes++;
        end else begin
          faces_due = {faces_due, cull_faces(cell_x_i, cell_y_i, cell_z_i)};
          cell_queries++;
        end
      end
    end
  end

  task automatic push_item(input logic op, input logic [COORD_W-1:0] x,
                           input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z,
                           input logic [NTYPE_W-1:0] t);
    voxel_item_t it;
    it.op    = op;
    it.x     = x;
    it.y     = y;
    it.z     = z;
    it.ntype = t;
    stim_items = {stim_items, it};
  endtask

  task automatic queue_random(input int unsigned count);
    @(posedge clk_i);
    repeat (count) stim_items = {stim_items, random_item()};
  endtask

  // Wait for every item and result to transfer, then let the block settle
  task automatic wait_idle();
    @(posedge clk_i);
    while (stim_items.size() != 0 || in_valid_i || faces_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ORIGIN_X: org_x = val;
      CFG_ORIGIN_Y: org_y = val;
      CFG_ORIGIN_Z: org_z = val;
      default: ;
    endcase
  endtask

  task automatic set_origin(input logic [CFG_DATA_W-1:0] ox,
                            input logic [CFG_DATA_W-1:0] oy,
                            input logic [CFG_DATA_W-1:0] oz);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    origin_sets++;
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    set_origin(16'h0000, 16'h0000, 16'h0000);

    // Fill the whole chunk before any query can read it
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    @(posedge clk_i);
    for (int unsigned a = 0; a < STORE_DEPTH; a++)
      push_item(OP_WRITE, a[11:8], a[7:4], a[3:0], pick_type());

    // Centre cell with six solid neighbours shows nothing
    push_item(OP_WRITE, 7, 8, 9, 15);
    push_item(OP_WRITE, 7, 8, 8, 1);
    push_item(OP_WRITE, 8, 8, 9, 1);
    push_item(OP_WRITE, 7, 8, 10, 1);
    push_item(OP_WRITE, 6, 8, 9, 1);
    push_item(OP_WRITE, 7, 9, 9, 1);
    push_item(OP_WRITE, 7, 7, 9, 1);
    push_item(OP_QUERY, 7, 8, 9, 0);
    // Open one face at a time, in mask bit order
    push_item(OP_WRITE, 7, 8, 8, 0);
    push_item(OP_QUERY, 7, 8, 9, 0);
    push_item(OP_WRITE, 8, 8, 9, 0);
    push_item(OP_QUERY, 7, 8, 9, 0);
    push_item(OP_WRITE, 7, 8, 10, 0);
    push_item(OP_QUERY, 7, 8, 9, 0);
    push_item(OP_WRITE, 6, 8, 9, 0);
    push_item(OP_QUERY, 7, 8, 9, 0);
    push_item(OP_WRITE, 7, 9, 9, 0);
    push_item(OP_QUERY, 7, 8, 9, 0);
    push_item(OP_WRITE, 7, 7, 9, 0);
    push_item(OP_QUERY, 7, 8, 9, 0);
    // Boundary corners and an air cell
    push_item(OP_WRITE, 0, 0, 0, 9);
    push_item(OP_QUERY, 0, 0, 0, 15);
    push_item(OP_QUERY, 15, 15, 15, 0);
    push_item(OP_WRITE, 3, 3, 3, 0);
    push_item(OP_QUERY, 3, 3, 3, 0);
    wait_idle();

    // Extreme origins, no idling on either side
    set_origin(16'h7FFF, 16'h8000, 16'hFFFF);
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    queue_random(PHASE_ITEMS);
    wait_idle();

    // Index past the register list must leave the origin alone
    set_origin(16'h8000, 16'h7FFF, 16'h0000);
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
    // Long receiver hold while the sender keeps offering items
    rx_stalls = 1'b1;
    @(posedge clk_i);
    rx_hold_req++;
    queue_random(PHASE_ITEMS);
    wait_idle();

    set_origin(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
    tx_gaps = 1'b1;
    queue_random(PHASE_ITEMS);
    wait_idle();

    set_origin(16'hFFFF, 16'h0001, 16'h7FF1);
    rx_stalls = 1'b0;
    queue_random(PHASE_ITEMS);
    wait_idle();

    set_origin(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()));
    rx_stalls = 1'b1;
    queue_random(PHASE_ITEMS);
    wait_idle();

    $display("checked %0d face results from %0d queries and %0d cell writes",
             faces_checked, cell_queries, cell_writes);
    $display("ran under %0d chunk origins, with gaps and stalls on both channels",
             origin_sets);
    if (fail_count == 0) begin
      $display("voxel_face_visibility_unit verification clean");
    end else begin
      $display("voxel_face_visibility_unit verification failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * RUN_LIMIT);
    $display("voxel_face_visibility_unit verification failed");
    $finish;
  end

endmodule
